@@ src/gb5_pkg.sv @@
package gb5_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 10;
    localparam int WIN       = 5;
    localparam int LINES     = 4;
    localparam int MIN_SIZE  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd420;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd280;

    // weighted row: at most 49 * 255; whole window: at most 159 * 255
    localparam int ROW_SUM_W = 14;
    localparam int TOTAL_W   = 16;

    // floor(x / 159) = (x * 105518) >> 24, exact for x < 2^16
    localparam int                   RECIP_W   = 17;
    localparam logic [RECIP_W-1:0]   DIV_RECIP = 17'd105518;
    localparam int                   DIV_SHIFT = 24;
    localparam int                   PROD_W    = 32;

    localparam logic [3:0] BLUR_W [0:WIN-1][0:WIN-1] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN-1:0][PIX_W-1:0] t_column;
    typedef logic [WIN-1:0][ROW_SUM_W-1:0] t_row_sums;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_side;

endpackage

@@ src/gb5_ram.sv @@
module gb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/gb5_window.sv @@
module gb5_window (
    input  logic                i_clk,
    input  logic                i_shift,
    input  gb5_pkg::t_column    i_column,
    input  logic                i_load,
    output gb5_pkg::t_row_sums  o_row_sum
);

    localparam int RSW = gb5_pkg::ROW_SUM_W;
    localparam int WN  = gb5_pkg::WIN;

    gb5_pkg::t_pix      r_win [0:WN-1][0:WN-1];
    gb5_pkg::t_row_sums n_row_sum;
    gb5_pkg::t_row_sums r_row_sum;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < WN; i++) begin
                for (int j = 0; j < WN - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][WN-1] <= i_column[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WN; i++) begin
            n_row_sum[i] = '0;
            for (int j = 0; j < WN; j++) begin
                n_row_sum[i] = n_row_sum[i]
                             + RSW'(gb5_pkg::BLUR_W[i][j]) * RSW'(r_win[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row_sum <= n_row_sum;
        end
    end

    assign o_row_sum = r_row_sum;

endmodule

@@ src/gb5_div159.sv @@
module gb5_div159 (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  gb5_pkg::t_row_sums        i_row_sum,
    output logic [gb5_pkg::PIX_W-1:0] o_quot
);

    localparam int TW = gb5_pkg::TOTAL_W;
    localparam int PW = gb5_pkg::PROD_W;

    logic [TW-1:0] n_total;
    logic [TW-1:0] r_total;
    logic [PW-1:0] r_prod;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < gb5_pkg::WIN; i++) begin
            n_total = n_total + TW'(i_row_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_total <= n_total;
            r_prod  <= PW'(r_total) * PW'(gb5_pkg::DIV_RECIP);
        end
    end

    assign o_quot = r_prod[gb5_pkg::DIV_SHIFT +: gb5_pkg::PIX_W];

endmodule

@@ src/gaussian_blur_5x5_top.sv @@
// 5x5 Gaussian blur (mask 2,4,5,4,2 / 4,9,12,9,4 / 5,12,15,12,5, sum / 159).
// Input channel: one luma pixel per beat, raster order. Output channel: one
// blurred pixel per window that lies fully inside the frame, with the
// centre's row and column; frame_last marks the final pixel of a frame.
// Border centres give no output beat.
// Config channel: index 0 frame width, index 1 frame height, always ready;
// sizes are clamped to 5..MAX_WIDTH / 5..MAX_HEIGHT. Write only when idle.
// Throughput: one pixel per cycle while not stalled. The four previous rows
// sit in one MAX_WIDTH x 32-bit RAM, read at the column on acceptance and
// written back from stage 1, so one read and one write per pixel.
// Pipeline stages from input beat to output valid: RAM read, window,
// row sums, total, reciprocal multiply, output register.
// Stall: when the output register holds an untaken beat, the whole pipeline
// and o_ready hold; a taken output frees it in the same cycle.
// Reset: position returns to the frame start, sizes to 420 x 280, pipeline
// empty. The RAM needs no clearing.
module gaussian_blur_5x5_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gb5_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gb5_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [gb5_pkg::COORD_W-1:0]   o_center_row,
    output logic [gb5_pkg::COORD_W-1:0]   o_center_col,
    output logic                          o_frame_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gb5_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gb5_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW0 = (WW > HW) ? WW : HW;
    localparam int SW  = (SW0 > gb5_pkg::CFG_W) ? SW0 : gb5_pkg::CFG_W;
    localparam int CO  = gb5_pkg::COORD_W;
    localparam int PW  = gb5_pkg::PIX_W;
    localparam int LW  = gb5_pkg::LINES * PW;

    logic [gb5_pkg::CFG_W-1:0] r_frame_width;
    logic [gb5_pkg::CFG_W-1:0] r_frame_height;
    logic [AW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic [AW-1:0]             n_col;
    logic [RW-1:0]             n_row;

    logic [SW-1:0] w_cfg, h_cfg, w_eff, h_eff, c_x, r_x, c_rx, r_rx;
    logic          emit;
    gb5_pkg::t_side side;

    logic pipe_en, in_acc;

    logic           r_s1_valid, r_s1_emit;
    gb5_pkg::t_pix  r_s1_px;
    logic [AW-1:0]  r_s1_addr;
    gb5_pkg::t_side r_s1_side;
    logic           r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    gb5_pkg::t_side r_s2_side, r_s3_side, r_s4_side, r_s5_side;

    logic                 r_o_valid;
    gb5_pkg::t_pix        r_o_pix;
    gb5_pkg::t_side       r_o_side;

    logic [LW-1:0]        rd_data, wr_data;
    logic                 wr_en;
    gb5_pkg::t_column     column;
    gb5_pkg::t_row_sums   row_sum;
    gb5_pkg::t_pix        quot;

    assign pipe_en     = !r_o_valid || i_ready;
    assign in_acc      = i_valid && pipe_en;
    assign o_ready     = pipe_en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg = SW'(r_frame_width);
        h_cfg = SW'(r_frame_height);
        if (w_cfg < SW'(gb5_pkg::MIN_SIZE)) begin
            w_eff = SW'(gb5_pkg::MIN_SIZE);
        end else if (w_cfg > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (h_cfg < SW'(gb5_pkg::MIN_SIZE)) begin
            h_eff = SW'(gb5_pkg::MIN_SIZE);
        end else if (h_cfg > SW'(MAX_HEIGHT)) begin
            h_eff = SW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end

        c_x  = SW'(r_col);
        r_x  = SW'(r_row);
        c_rx = c_x - SW'(2);
        r_rx = r_x - SW'(2);
        emit = (r_x >= SW'(gb5_pkg::WIN - 1)) && (c_x >= SW'(gb5_pkg::WIN - 1))
            && (r_x < h_eff) && (c_x < w_eff);
        side.row  = r_rx[CO-1:0];
        side.col  = c_rx[CO-1:0];
        side.last = (r_x == h_eff - SW'(1)) && (c_x == w_eff - SW'(1));

        if (c_x + SW'(1) >= w_eff) begin
            n_col = '0;
            n_row = (r_x + SW'(1) >= h_eff) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + AW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= gb5_pkg::RST_FRAME_WIDTH;
            r_frame_height <= gb5_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gb5_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                gb5_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (pipe_en) begin
                r_s1_valid <= i_valid;
                r_s2_valid <= r_s1_valid && r_s1_emit;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                r_s5_valid <= r_s4_valid;
                r_o_valid  <= r_s5_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel_in;
            r_s1_addr <= r_col;
            r_s1_emit <= emit;
            r_s1_side <= side;
        end
        if (pipe_en) begin
            r_s2_side <= r_s1_side;
            r_s3_side <= r_s2_side;
            r_s4_side <= r_s3_side;
            r_s5_side <= r_s4_side;
            r_o_side  <= r_s5_side;
            r_o_pix   <= quot;
        end
    end

    // lane i holds the row 4 - i lines above the incoming one, oldest in lane 0
    always_comb begin
        for (int i = 0; i < gb5_pkg::LINES; i++) begin
            column[i] = rd_data[i*PW +: PW];
        end
        column[gb5_pkg::LINES] = r_s1_px;
        for (int i = 0; i < gb5_pkg::LINES; i++) begin
            wr_data[i*PW +: PW] = column[i+1];
        end
    end

    assign wr_en = pipe_en && r_s1_valid;

    gb5_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    gb5_window u_window (
        .i_clk     (i_clk),
        .i_shift   (wr_en),
        .i_column  (column),
        .i_load    (pipe_en),
        .o_row_sum (row_sum)
    );

    gb5_div159 u_div (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_row_sum (row_sum),
        .o_quot    (quot)
    );

    assign o_valid      = r_o_valid;
    assign o_pixel_out  = r_o_pix;
    assign o_center_row = r_o_side.row;
    assign o_center_col = r_o_side.col;
    assign o_frame_last = r_o_side.last;

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && in_acc && (r_s1_addr == r_col)))
        else $error("line RAM read and write hit the same column");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !pipe_en |=> r_s1_valid)
        else $error("pixel waiting on RAM data lost during stall");

    a_centre_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_center_row >= CO'(2)) && (o_center_col >= CO'(2)))
        else $error("border centre emitted");

endmodule
